// ----- rtl/int4gdd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int4gdd_pkg
// Types and fixed widths shared by the int4 group dequant dot product block.
// ----------------------------------------------------------------------------
package int4gdd_pkg;

  localparam int TERM_W = 25;   // (nibble*16 - zp) * x_even + same for odd
  localparam int GACC_W = 40;   // group accumulator, wraps
  localparam int RACC_W = 48;   // row accumulator, saturates
  localparam int PROD_W = 57;   // group sum times unsigned scale
  localparam int ADD_W  = 41;   // rounded scaled group sum
  localparam int OUT_W  = 32;   // row_sum, Q15.16

  localparam logic [3:0] NIB_MASK      = 4'hF;
  localparam int         OUT_MAX_SHIFT = 31;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  // One queued item, already reduced to its exact term, scale and close flags
  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic [15:0]              scale;
    logic                     grp_end;
    logic                     row_end;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] row_sum;
    logic                    saturated;
  } result_t;

endpackage

// ----- rtl/int4gdd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int4gdd_fifo
// Small first-word-fall-through queue, register storage.
// ----------------------------------------------------------------------------
module int4gdd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/int4gdd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int4gdd_front
// Accepts items, forms the exact per-byte term and the close flags.
// ----------------------------------------------------------------------------
module int4gdd_front
  import int4gdd_pkg::*;
(
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_weight_byte,
  input  logic signed [15:0] in_x_even,
  input  logic signed [15:0] in_x_odd,
  input  logic               in_odd_used,
  input  logic [15:0]        in_scale,
  input  logic [7:0]         in_zp,
  input  logic               in_group_last,
  input  logic               in_row_last,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);

  logic [3:0]               nib_lo, nib_hi;
  logic signed [9:0]        d_lo, d_hi;
  logic signed [TERM_W-1:0] p_lo, p_hi, p_hi_g, p_sum;

  // weight minus zero point, both in Q4.4
  assign nib_lo = in_weight_byte[3:0] & NIB_MASK;
  assign nib_hi = in_weight_byte[7:4] & NIB_MASK;
  assign d_lo   = $signed({2'b00, nib_lo, 4'b0000}) - $signed({2'b00, in_zp});
  assign d_hi   = $signed({2'b00, nib_hi, 4'b0000}) - $signed({2'b00, in_zp});

  // each product fits 24 bits, their sum fits TERM_W
  assign p_lo   = TERM_W'(d_lo) * TERM_W'(in_x_even);
  assign p_hi   = TERM_W'(d_hi) * TERM_W'(in_x_odd);
  assign p_hi_g = in_odd_used ? p_hi : '0;
  assign p_sum  = p_lo + p_hi_g;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    q_item.term    = p_sum;
    q_item.scale   = in_scale;
    q_item.grp_end = in_group_last || in_row_last;  // row end closes the group
    q_item.row_end = in_row_last;
  end

endmodule

// ----- rtl/int4gdd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int4gdd_back
// Group accumulate, scale, round, row accumulate and clip pipeline.
// ----------------------------------------------------------------------------
module int4gdd_back
  import int4gdd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  item_t   q_item,
  input  logic    q_empty,
  output logic    q_pop,
  input  logic    o_full,
  output logic    o_push,
  output result_t o_data
);

  logic en;

  // S1: group accumulator
  logic signed [GACC_W-1:0] gacc_r, gsum, ga_r;
  logic [15:0]              s1_scale_r;
  logic                     s1_v_r, s1_row_r;
  // S2: scale multiply
  logic signed [PROD_W-1:0] prod_nxt, prod_r, rnd;
  logic                     s2_v_r, s2_row_r;
  // S3: round to Q.16
  logic signed [ADD_W-1:0]  add_r;
  logic                     s3_v_r, s3_row_r;
  // S4: row accumulator
  logic signed [RACC_W:0]   r_wide;
  logic signed [RACC_W-1:0] racc_r, r_sat, res_r;
  logic                     s4_v_r;
  // S5: clip and output register
  result_t                  clip_nxt, out_r;
  logic                     out_v_r;

  assign en     = !out_v_r || !o_full;
  assign q_pop  = en && !q_empty;
  assign o_push = out_v_r && !o_full;
  assign o_data = out_r;

  assign gsum = gacc_r + {{(GACC_W-TERM_W){q_item.term[TERM_W-1]}}, q_item.term};

  assign prod_nxt = PROD_W'(ga_r) * PROD_W'($signed({1'b0, s1_scale_r}));
  assign rnd      = prod_r + ROUND_HALF;

  assign r_wide = {racc_r[RACC_W-1], racc_r}
                + {{(RACC_W+1-ADD_W){add_r[ADD_W-1]}}, add_r};

  always_comb begin
    if (r_wide[RACC_W] != r_wide[RACC_W-1]) begin
      r_sat = r_wide[RACC_W] ? {1'b1, {(RACC_W-1){1'b0}}} : {1'b0, {(RACC_W-1){1'b1}}};
    end else begin
      r_sat = r_wide[RACC_W-1:0];
    end
  end

  // fits Q15.16 when all bits from the output sign bit up agree
  always_comb begin
    if (&res_r[RACC_W-1:OUT_MAX_SHIFT] || ~|res_r[RACC_W-1:OUT_MAX_SHIFT]) begin
      clip_nxt.row_sum   = res_r[OUT_W-1:0];
      clip_nxt.saturated = 1'b0;
    end else begin
      clip_nxt.row_sum   = res_r[RACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                           : {1'b0, {(OUT_W-1){1'b1}}};
      clip_nxt.saturated = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gacc_r  <= '0;
      racc_r  <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      if (q_pop) begin
        gacc_r <= q_item.grp_end ? '0 : gsum;
      end
      if (s3_v_r) begin
        racc_r <= s3_row_r ? '0 : r_sat;
      end
      s1_v_r  <= q_pop && q_item.grp_end;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r && s3_row_r;
      out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ga_r       <= gsum;
      s1_scale_r <= q_item.scale;
      s1_row_r   <= q_item.row_end;
      prod_r     <= prod_nxt;
      s2_row_r   <= s1_row_r;
      add_r      <= rnd[PROD_W-1:16];
      s3_row_r   <= s2_row_r;
      res_r      <= r_sat;
      out_r      <= clip_nxt;
    end
  end

endmodule

// ----- rtl/int4_group_dequant_dot_top.sv -----
`timescale 1ns / 1ps
// Path: a row result reaches the out_ ports through the queue, the 4 back
//   stages, output register and result queue; the back stages stall on o_full.
// Throughput: one packed weight byte per cycle while in_full is low, set by
//   the front multipliers and the group accumulator loop of the back end.
// Reset (rst_n low, synchronous): both accumulators, both queues and all
//   stage valid bits clear; in_full is low on the first cycle after reset.
// ----------------------------------------------------------------------------
// int4_group_dequant_dot_top
// int4 group-quantized row times Q3.12 vector, emitting a Q15.16 row sum.
// ----------------------------------------------------------------------------
module int4_group_dequant_dot_top
  import int4gdd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4,   // front-to-back decoupling queue
  parameter int OUT_DEPTH   = 4    // result queue
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_weight_byte,
  input  logic signed [15:0] in_x_even,
  input  logic signed [15:0] in_x_odd,
  input  logic               in_odd_used,
  input  logic [15:0]        in_scale,
  input  logic [7:0]         in_zp,
  input  logic               in_group_last,
  input  logic               in_row_last,
  // result channel
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_row_sum,
  output logic               out_saturated
);

  // Front: each accepted transaction is reduced to one exact 25-bit term
  // (each used nibble minus zero point, times its activation) plus flags
  // telling the back end whether it closes a group and/or the row.
  item_t   f_item, b_item;
  logic    f_push, q_full, q_empty, q_pop;
  logic [$bits(item_t)-1:0] q_dout;

  // Back: result transactions leave through a small output queue; the back
  // pipeline stalls as a whole only when that queue is full.
  result_t b_res, o_res;
  logic    b_push, o_full;
  logic [$bits(result_t)-1:0] o_dout;

  int4gdd_front u_front (
    .in_push        (in_push),
    .in_full        (in_full),
    .in_weight_byte (in_weight_byte),
    .in_x_even      (in_x_even),
    .in_x_odd       (in_x_odd),
    .in_odd_used    (in_odd_used),
    .in_scale       (in_scale),
    .in_zp          (in_zp),
    .in_group_last  (in_group_last),
    .in_row_last    (in_row_last),
    .q_full         (q_full),
    .q_push         (f_push),
    .q_item         (f_item)
  );

  int4gdd_fifo #(
    .W     ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign b_item = item_t'(q_dout);

  // Group close: scaled sum rounded half up to Q.16, added to a saturating
  // 48-bit row sum. Row close: row sum clipped to Q15.16 with a flag.
  int4gdd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (b_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (b_push),
    .o_data  (b_res)
  );

  int4gdd_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_push),
    .din   (b_res),
    .full  (o_full),
    .pop   (out_pop),
    .dout  (o_dout),
    .empty (out_empty)
  );

  assign o_res         = result_t'(o_dout);
  assign out_row_sum   = o_res.row_sum;
  assign out_saturated = o_res.saturated;

endmodule

// ----- rtl/int4gdd_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int4gdd_chk
// Port-level checks on the int4 group dequant dot top level.
// ----------------------------------------------------------------------------
module int4gdd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_row_sum,
  input logic               out_saturated
);

  // reset drains the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // reset opens the input side
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // a waiting transaction holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_row_sum)
                              && $stable(out_saturated))
    else $error("waiting result changed");

  // a clipped result sits exactly on one of the Q15.16 bounds
  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_saturated |->
      out_row_sum == 32'sh7FFFFFFF || out_row_sum == 32'sh80000000)
    else $error("saturated flag with in-range row_sum");

endmodule

bind int4_group_dequant_dot_top int4gdd_chk u_chk (.*);
